// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file ibp_checker.sv.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("check failed");
`endif

// ----- sv/ibp_pkg.sv -----
// Package for the icon blob parser: result kinds, error codes, config indices, result record.
// Depends on nothing.
`timescale 1ns / 1ps
package ibp_pkg;
	localparam logic [2:0] KIND_ID = 3'd0;
	localparam logic [2:0] KIND_HDR = 3'd1;
	localparam logic [2:0] KIND_PIX = 3'd2;
	localparam logic [2:0] KIND_OK = 3'd3;
	localparam logic [2:0] KIND_REJ = 3'd4;
	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_MAGIC = 3'd1;
	localparam logic [2:0] ERR_VER = 3'd2;
	localparam logic [2:0] ERR_TRUNC = 3'd3;
	localparam logic [2:0] ERR_GEOM = 3'd4;
	localparam logic [2:0] ERR_IDLEN = 3'd5;
	localparam logic [2:0] ERR_TRAIL = 3'd6;
	localparam logic [1:0] CFG_VERSION = 2'd0;
	localparam logic [1:0] CFG_MAXDIM = 2'd1;
	localparam logic [1:0] CFG_MAXFRM = 2'd2;
	localparam logic [1:0] CFG_MAXID = 2'd3;
	localparam logic [15:0] DEFAULT_FRAME_MS = 16'd100;
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] id_char;
		logic [7:0] w;
		logic [7:0] h;
		logic [7:0] f;
		logic keyed;
		logic [15:0] ms;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [2:0] err;
		logic run_end;
	} res_t;
endpackage

// ----- sv/icon_blob_parser_top.sv -----
// Top level of the icon blob parser: byte sequencer, result queue, registers.
// Depends on ibp_pkg and ibp_mul.
`timescale 1ns / 1ps
// One blob byte is taken per word. A byte that makes no result leaves the input ready
// for the next byte; a byte that makes results holds the input until its words have
// drained from a two-entry queue. The ninth header byte runs a shared shift-and-add
// unit twice (width*height, then *frames), and the input is held until both products
// are done. Output words leave a register stage.
module icon_blob_parser_top
	import ibp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] kind,
	output logic [7:0] id_char,
	output logic [7:0] icon_width,
	output logic [7:0] icon_height,
	output logic [7:0] frame_total,
	output logic keyed,
	output logic [15:0] frame_ms,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [2:0] error_code,
	output logic run_end,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);
	localparam logic [2:0] PH_MAGIC = 3'd0;
	localparam logic [2:0] PH_VER = 3'd1;
	localparam logic [2:0] PH_CNT = 3'd2;
	localparam logic [2:0] PH_IDLEN = 3'd3;
	localparam logic [2:0] PH_ID = 3'd4;
	localparam logic [2:0] PH_HDR = 3'd5;
	localparam logic [2:0] PH_PIX = 3'd6;
	localparam logic [2:0] PH_DONE = 3'd7;
	localparam logic [1:0] SQ_IDLE = 2'd0;
	localparam logic [1:0] SQ_MUL1 = 2'd1;
	localparam logic [1:0] SQ_MUL2 = 2'd2;
	localparam logic [1:0] SQ_FIN = 2'd3;

	logic [7:0] ver_q, maxdim_q, maxfrm_q, maxid_q;
	logic [2:0] ph_q;
	logic [3:0] fpos_q;
	logic [7:0] icons_q, idl_q;
	logic [7:0] w_q, h_q, f_q;
	logic flag_q;
	logic [15:0] tm_q;
	logic [23:0] col_q;
	logic [23:0] pix_q;
	logic [1:0] pp_q;
	logic [15:0] pb_q;
	logic disc_q;
	logic last_q;
	logic [1:0] sq_q;
	res_t q0_q, q1_q;
	logic [1:0] qn_q;

	logic mul_start, mul_busy;
	logic [15:0] mul_a;
	logic [7:0] mul_b;
	logic [23:0] mul_p;

	ibp_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .prod(mul_p)
	);

	assign cfg_ready = 1'b1;
	assign in_ready = (qn_q == 2'd0) && (sq_q == SQ_IDLE);
	assign out_valid = (qn_q != 2'd0);
	assign kind = q0_q.kind;
	assign id_char = q0_q.id_char;
	assign icon_width = q0_q.w;
	assign icon_height = q0_q.h;
	assign frame_total = q0_q.f;
	assign keyed = q0_q.keyed;
	assign frame_ms = q0_q.ms;
	assign red = q0_q.r;
	assign green = q0_q.g;
	assign blue = q0_q.b;
	assign error_code = q0_q.err;
	assign run_end = q0_q.run_end;

	logic acc;
	assign acc = in_valid && in_ready;

	logic [7:0] magic_c;
	always_comb begin
		case (fpos_q[1:0])
			2'd0: magic_c = 8'h4E;
			2'd1: magic_c = 8'h49;
			default: magic_c = 8'h43;
		endcase
	end

	logic geom_bad;
	assign geom_bad = (w_q == 8'd0) || (h_q == 8'd0) || (f_q == 8'd0) ||
		(w_q > maxdim_q) || (h_q > maxdim_q) || (f_q > maxfrm_q);

	assign mul_start = (acc && !disc_q && ph_q == PH_HDR && fpos_q == 4'd8) ||
		(sq_q == SQ_MUL1 && !mul_busy);
	assign mul_a = (sq_q == SQ_MUL1) ? mul_p[15:0] : {8'd0, w_q};
	assign mul_b = (sq_q == SQ_MUL1) ? f_q : h_q;

	// Byte step: results and next state for the accepted byte.
	res_t r0, r1;
	logic [1:0] n_c;
	logic [2:0] err_c;
	logic [2:0] ph_n;
	logic [3:0] fpos_n;
	logic [7:0] icons_n, idl_n;
	logic [23:0] pix_n;
	logic [1:0] pp_n;
	logic have0;
	always_comb begin
		r0 = '0;
		have0 = 1'b0;
		err_c = ERR_NONE;
		ph_n = ph_q;
		fpos_n = fpos_q;
		icons_n = icons_q;
		idl_n = idl_q;
		pix_n = pix_q;
		pp_n = pp_q;
		unique case (ph_q)
			PH_MAGIC: begin
				if (fpos_q > 4'd2 || data_byte != magic_c) err_c = ERR_MAGIC;
				else if (fpos_q == 4'd2) begin
					ph_n = PH_VER;
					fpos_n = 4'd0;
				end else fpos_n = fpos_q + 4'd1;
			end
			PH_VER: begin
				if (data_byte != ver_q) err_c = ERR_VER;
				else ph_n = PH_CNT;
			end
			PH_CNT: begin
				icons_n = data_byte;
				ph_n = (data_byte != 8'd0) ? PH_IDLEN : PH_DONE;
			end
			PH_IDLEN: begin
				if (data_byte == 8'd0 || data_byte > maxid_q) err_c = ERR_IDLEN;
				else begin
					idl_n = data_byte;
					ph_n = PH_ID;
				end
			end
			PH_ID: begin
				have0 = 1'b1;
				r0.kind = KIND_ID;
				r0.id_char = data_byte;
				idl_n = idl_q - 8'd1;
				if (idl_q == 8'd1) begin
					ph_n = PH_HDR;
					fpos_n = 4'd0;
				end
			end
			PH_HDR: begin
				if (fpos_q < 4'd8) fpos_n = fpos_q + 4'd1;
				else fpos_n = 4'd0;
			end
			PH_PIX: begin
				if (pp_q == 2'd2) begin
					have0 = 1'b1;
					r0.kind = KIND_PIX;
					r0.r = pb_q[15:8];
					r0.g = pb_q[7:0];
					r0.b = data_byte;
					pp_n = 2'd0;
					pix_n = pix_q - 24'd1;
					if (pix_q == 24'd1) begin
						icons_n = icons_q - 8'd1;
						ph_n = (icons_q == 8'd1) ? PH_DONE : PH_IDLEN;
					end
				end else pp_n = pp_q + 2'd1;
			end
			PH_DONE: err_c = ERR_TRAIL;
			default: ;
		endcase
		r0.run_end = (err_c == ERR_NONE) && !last_byte;
	end

	// Tail builder, shared by the byte step, the geometry reject and the header finish.
	function automatic res_t tail(input logic [2:0] e, input logic [2:0] ph);
		res_t t;
		begin
			t = '0;
			if (e != ERR_NONE) begin
				t.kind = KIND_REJ;
				t.err = e;
			end else if (ph == PH_DONE) t.kind = KIND_OK;
			else begin
				t.kind = KIND_REJ;
				t.err = ERR_TRUNC;
			end
			t.run_end = 1'b1;
			return t;
		end
	endfunction

	assign r1 = tail(err_c, ph_n);

	logic hdr_defer;
	assign hdr_defer = (ph_q == PH_HDR) && (fpos_q == 4'd8);

	res_t hdr_r;
	always_comb begin
		hdr_r = '0;
		hdr_r.kind = KIND_HDR;
		hdr_r.w = w_q;
		hdr_r.h = h_q;
		hdr_r.f = f_q;
		hdr_r.keyed = flag_q;
		hdr_r.ms = (tm_q != 16'd0) ? tm_q : DEFAULT_FRAME_MS;
		hdr_r.r = col_q[23:16];
		hdr_r.g = col_q[15:8];
		hdr_r.b = col_q[7:0];
		hdr_r.run_end = !last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q <= 8'd1;
			maxdim_q <= 8'd32;
			maxfrm_q <= 8'd16;
			maxid_q <= 8'd32;
			ph_q <= PH_MAGIC;
			fpos_q <= 4'd0;
			icons_q <= 8'd0;
			idl_q <= 8'd0;
			pix_q <= 24'd0;
			pp_q <= 2'd0;
			disc_q <= 1'b0;
			sq_q <= SQ_IDLE;
			qn_q <= 2'd0;
			last_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_VERSION: ver_q <= cfg_data;
					CFG_MAXDIM: maxdim_q <= cfg_data;
					CFG_MAXFRM: maxfrm_q <= cfg_data;
					CFG_MAXID: maxid_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				q0_q <= q1_q;
				qn_q <= qn_q - 2'd1;
			end
			if (acc) begin
				last_q <= last_byte;
				if (disc_q) begin
					if (last_byte) begin
						disc_q <= 1'b0;
						ph_q <= PH_MAGIC;
						fpos_q <= 4'd0;
						pp_q <= 2'd0;
					end
				end else if (hdr_defer) begin
					fpos_q <= 4'd0;
					if (geom_bad) begin
						q0_q <= tail(ERR_GEOM, ph_q);
						qn_q <= 2'd1;
						disc_q <= !last_byte;
						ph_q <= PH_MAGIC;
						pp_q <= 2'd0;
					end else sq_q <= SQ_MUL1;
				end else begin
					icons_q <= icons_n;
					idl_q <= idl_n;
					pix_q <= pix_n;
					if (err_c != ERR_NONE || last_byte) begin
						ph_q <= PH_MAGIC;
						fpos_q <= 4'd0;
						pp_q <= 2'd0;
						disc_q <= (err_c != ERR_NONE) && !last_byte;
						if (have0) begin
							q0_q <= r0;
							q1_q <= r1;
							qn_q <= 2'd2;
						end else begin
							q0_q <= r1;
							qn_q <= 2'd1;
						end
					end else begin
						ph_q <= ph_n;
						fpos_q <= fpos_n;
						pp_q <= pp_n;
						if (have0) begin
							q0_q <= r0;
							qn_q <= 2'd1;
						end
					end
				end
			end
			unique case (sq_q)
				SQ_IDLE: ;
				SQ_MUL1: if (!mul_busy) sq_q <= SQ_MUL2;
				SQ_MUL2: if (!mul_busy) sq_q <= SQ_FIN;
				SQ_FIN: begin
					sq_q <= SQ_IDLE;
					pix_q <= mul_p;
					pp_q <= 2'd0;
					q0_q <= hdr_r;
					if (last_q) begin
						q1_q <= tail(ERR_NONE, PH_PIX);
						qn_q <= 2'd2;
						ph_q <= PH_MAGIC;
					end else begin
						qn_q <= 2'd1;
						ph_q <= PH_PIX;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !disc_q && ph_q == PH_HDR) begin
			unique case (fpos_q)
				4'd0: w_q <= data_byte;
				4'd1: h_q <= data_byte;
				4'd2: f_q <= data_byte;
				4'd3: flag_q <= data_byte[0];
				4'd4: tm_q <= {8'd0, data_byte};
				4'd5: tm_q[15:8] <= data_byte;
				4'd6: col_q[23:16] <= data_byte;
				4'd7: col_q[15:8] <= data_byte;
				default: col_q[7:0] <= data_byte;
			endcase
		end
		if (acc && !disc_q && ph_q == PH_PIX) begin
			if (pp_q == 2'd0) pb_q[15:8] <= data_byte;
			else if (pp_q == 2'd1) pb_q[7:0] <= data_byte;
		end
	end
endmodule

// ----- sv/ibp_mul.sv -----
// Shift-and-add multiplier for the pixel count, one bit per cycle.
// Depends on ibp_pkg.
`timescale 1ns / 1ps
module ibp_mul
	import ibp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] a,
	input logic [7:0] b,
	output logic busy,
	output logic [23:0] prod
);
	logic [23:0] acc_q;
	logic [23:0] a_q;
	logic [7:0] b_q;
	logic [3:0] cnt_q;
	assign busy = (cnt_q != 4'd0);
	assign prod = acc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (start) begin
			cnt_q <= 4'd8;
		end else if (busy) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= 24'd0;
			a_q <= {8'd0, a};
			b_q <= b;
		end else if (busy) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[22:0], 1'b0};
			b_q <= {1'b0, b_q[7:1]};
		end
	end
endmodule

// ----- sv/ibp_checker.sv -----
// Port-level checks on the icon blob parser top level, bound to it.
// Depends on ibp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ibp_checker
	import ibp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] kind,
	input logic [2:0] error_code
);
	`CHK_IMPL(a_kind_range, clk, arst_n, out_valid, kind <= KIND_REJ)
	`CHK_IMPL(a_err_only_rej, clk, arst_n, out_valid && kind != KIND_REJ, error_code == ERR_NONE)
	`CHK_IMPL(a_no_in_while_out, clk, arst_n, out_valid, !in_ready)
	`CHK_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

bind icon_blob_parser_top ibp_checker u_ibp_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
	.error_code(error_code)
);
